FILE: hdl/combination_unrank_defines.svh
// assertion macros for the combination unranking block
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef COMBINATION_UNRANK_DEFINES_SVH
`define COMBINATION_UNRANK_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CU_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CU_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define CU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: hdl/cu_pkg.sv
// shared constants, types and helpers of the combination unranking block
// no dependencies
package cu_pkg;

   localparam int MAX_SET_SIZE    = 32;
   localparam int MAX_SUBSET_SIZE = 16;

   localparam int SET_W  = 6;
   localparam int SUB_W  = 5;
   localparam int RANK_W = 30;
   localparam int ELEM_W = 6;
   localparam int POS_W  = 4;

   // binomial table C(a,b), a in 0..MAX_SET_SIZE, b in 0..MAX_SUBSET_SIZE
   localparam int BINOM_ROWS  = MAX_SET_SIZE + 1;
   localparam int BINOM_COLS  = MAX_SUBSET_SIZE + 1;
   localparam int BINOM_DEPTH = BINOM_ROWS * BINOM_COLS;
   localparam int BINOM_AW    = $clog2(BINOM_DEPTH);
   localparam int BINOM_W     = RANK_W;
   localparam int ROW_W       = $clog2(BINOM_ROWS);
   localparam int COL_W       = $clog2(BINOM_COLS);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = SET_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_SIZE    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SUBSET_SIZE = CSR_INDEX_W'(1);

   localparam logic [SET_W-1:0] SET_SIZE_RESET    = SET_W'(32);
   localparam logic [SUB_W-1:0] SUBSET_SIZE_RESET = SUB_W'(1);

   typedef struct packed {
      logic                en;
      logic [BINOM_AW-1:0] addr;
      logic [BINOM_W-1:0]  data;
   } binom_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANGE,
      ST_ISSUE,
      ST_CHECK,
      ST_FINAL,
      ST_PUT
   } state_type;

   function automatic logic [BINOM_AW-1:0] binom_addr(input logic [SET_W-1:0] a,
                                                      input logic [SUB_W-1:0] b);
      binom_addr = BINOM_AW'(int'(a) * BINOM_COLS + int'(b));
   endfunction

endpackage

FILE: hdl/cu_channels.sv
// request and response channel interfaces of the combination unranking block
// depends on cu_pkg
interface cu_req_if import cu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RANK_W-1:0] rank;

   modport source (output valid, output rank, input ready);
   modport sink   (input valid, input rank, output ready);
endinterface

interface cu_rsp_if import cu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ELEM_W-1:0] element_value;
   logic [POS_W-1:0]  position;
   logic              last;
   logic              rank_error;

   modport source (output valid, output element_value, output position, output last,
                   output rank_error, input ready);
   modport sink   (input valid, input element_value, input position, input last,
                   input rank_error, output ready);
endinterface

FILE: hdl/cu_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module cu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/cu_binom_fill.sv
// builds the binomial table row by row after reset (pascal rule on a shift line)
// depends on cu_pkg
module cu_binom_fill import cu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   output binom_wr_type fill_wr,
   output logic         fill_done
);
   // line holds one row, highest column at tap 0
   logic [BINOM_W-1:0]  line_ff [BINOM_COLS];
   logic [BINOM_W-1:0]  line_in [BINOM_COLS];
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [BINOM_AW-1:0] base_ff, base_in;
   logic                done_ff, done_in;
   logic [BINOM_W-1:0]  value;

   always_comb begin
      // row zero has only column zero set
      value   = (col_ff == '0) ? line_ff[0] :
                (row_ff == '0) ? '0 : BINOM_W'(line_ff[0] + line_ff[1]);
      line_in = line_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      base_in = base_ff;
      done_in = done_ff;
      if (!done_ff) begin
         for (int t = 0; t < BINOM_COLS - 1; t++) begin
            line_in[t] = line_ff[t+1];
         end
         line_in[BINOM_COLS-1] = value;
         if (col_ff == '0) begin
            if (row_ff == ROW_W'(MAX_SET_SIZE)) begin
               done_in = 1'b1;
            end else begin
               row_in  = row_ff + 1'b1;
               base_in = base_ff + BINOM_AW'(BINOM_COLS);
               col_in  = COL_W'(MAX_SUBSET_SIZE);
            end
         end else begin
            col_in = col_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < BINOM_COLS; t++) begin
            line_ff[t] <= (t == BINOM_COLS - 1) ? BINOM_W'(1) : '0;
         end
         row_ff  <= '0;
         col_ff  <= COL_W'(MAX_SUBSET_SIZE);
         base_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         line_ff <= line_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         base_ff <= base_in;
         done_ff <= done_in;
      end
   end

   assign fill_wr.en   = !done_ff;
   assign fill_wr.addr = base_ff + BINOM_AW'(col_ff);
   assign fill_wr.data = value;
   assign fill_done    = done_ff;
endmodule

FILE: hdl/combination_unrank.sv
// top level: lexicographic combination unranking over a binomial table in ram
// depends on cu_pkg, cu_channels, cu_ram, cu_binom_fill, combination_unrank_defines.svh
//
//   channel   direction  transaction
//   req_port  in         one rank
//   rsp_port  out        one element (value, position, last, rank_error)
//   csr_*     in         register write, index 0 set_size, 1 subset_size
//
// after reset the binomial table is built; no request is taken meanwhile
// a rank runs through accept and range check, then per stepped element an issue step
// and one check step per candidate (the read for the next step goes out in the same cycle),
// then final and output steps
// a bad request gives one response with rank_error set
// a stalled response holds the output register; the engine waits only when it has
// the next element ready and the register is still full
`include "combination_unrank_defines.svh"

module combination_unrank import cu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   cu_req_if.sink                 req_port,
   cu_rsp_if.source               rsp_port,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);
   // configuration registers
   logic [SET_W-1:0] set_size_ff;
   logic [SUB_W-1:0] subset_size_ff;

   // table build and ram
   binom_wr_type        fill_wr;
   logic                fill_done;
   logic                rd_en;
   logic [BINOM_AW-1:0] rd_addr;
   logic [BINOM_W-1:0]  rd_data;

   // engine state
   state_type         state_ff, state_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [RANK_W-1:0] k_ff, k_in;
   logic [SET_W-1:0]  cur_ff, cur_in;
   logic [POS_W-1:0]  idx_ff, idx_in;
   logic [SET_W-1:0]  n_ff, n_in;
   logic [SUB_W-1:0]  p_ff, p_in;

   // pending result
   logic [ELEM_W-1:0] pend_elem_ff, pend_elem_in;
   logic [POS_W-1:0]  pend_pos_ff, pend_pos_in;
   logic              pend_last_ff, pend_last_in;
   logic              pend_err_ff, pend_err_in;

   // output register
   logic              rsp_valid_ff;
   logic [ELEM_W-1:0] rsp_elem_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic              rsp_last_ff;
   logic              rsp_err_ff;

   logic              req_accept;
   logic              out_free;
   logic              out_load;
   logic              static_bad;
   logic [SET_W-1:0]  cand;
   logic [SUB_W-1:0]  q_rem;
   logic [RANK_W:0]   sum;
   logic [RANK_W-1:0] offset;
   logic              last_middle;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff    <= SET_SIZE_RESET;
         subset_size_ff <= SUBSET_SIZE_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_SET_SIZE) begin
            set_size_ff <= csr_write_data[SET_W-1:0];
         end else if (csr_index == CSR_SUBSET_SIZE) begin
            subset_size_ff <= csr_write_data[SUB_W-1:0];
         end
      end
   end

   cu_binom_fill u_fill (
      .clock     (clock),
      .reset     (reset),
      .fill_wr   (fill_wr),
      .fill_done (fill_done)
   );

   cu_ram #(
      .WIDTH (BINOM_W),
      .DEPTH (BINOM_DEPTH)
   ) u_binom_ram (
      .clock   (clock),
      .wr_en   (fill_wr.en),
      .wr_addr (fill_wr.addr),
      .wr_data (fill_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_port.ready = (state_ff == ST_IDLE) && fill_done;
   assign req_accept     = req_port.valid && req_port.ready;
   assign out_free       = !rsp_valid_ff || rsp_port.ready;

   // request sanity before any table read
   assign static_bad = (set_size_ff == '0) || (subset_size_ff == '0)
                    || (set_size_ff > SET_W'(MAX_SET_SIZE))
                    || (subset_size_ff > SUB_W'(MAX_SUBSET_SIZE))
                    || (SET_W'(subset_size_ff) > set_size_ff)
                    || (req_port.rank == '0);

   // candidate under test and how many elements still follow it
   assign cand   = cur_ff + 1'b1;
   assign q_rem  = p_ff - SUB_W'(1) - SUB_W'(idx_ff);
   assign sum    = {1'b0, k_ff} + {1'b0, rd_data};
   assign offset = rank_ff - k_ff;
   // the element just placed is the last one found by stepping
   assign last_middle = (SUB_W'(idx_ff) + SUB_W'(2)) == p_ff;

   always_comb begin
      state_in     = state_ff;
      rank_in      = rank_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      pend_elem_in = pend_elem_ff;
      pend_pos_in  = pend_pos_ff;
      pend_last_in = pend_last_ff;
      pend_err_in  = pend_err_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      out_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rank_in = req_port.rank;
               n_in    = set_size_ff;
               p_in    = subset_size_ff;
               if (static_bad) begin
                  pend_elem_in = '0;
                  pend_pos_in  = '0;
                  pend_last_in = 1'b1;
                  pend_err_in  = 1'b1;
                  state_in     = ST_PUT;
               end else begin
                  // fetch C(n,p) for the range check
                  rd_en    = 1'b1;
                  rd_addr  = binom_addr(set_size_ff, subset_size_ff);
                  state_in = ST_RANGE;
               end
            end
         end
         ST_RANGE: begin
            pend_pos_in  = '0;
            pend_last_in = 1'b1;
            if (rank_ff > rd_data) begin
               pend_elem_in = '0;
               pend_err_in  = 1'b1;
               state_in     = ST_PUT;
            end else if (p_ff == SUB_W'(1)) begin
               // single element: the rank itself
               pend_elem_in = rank_ff[ELEM_W-1:0];
               pend_err_in  = 1'b0;
               state_in     = ST_PUT;
            end else begin
               cur_in   = '0;
               k_in     = '0;
               idx_in   = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            rd_en    = 1'b1;
            rd_addr  = binom_addr(n_ff - cand, q_rem);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cur_in = cand;
            if ((sum < {1'b0, rank_ff}) && (cand < n_ff)) begin
               // keep stepping, next candidate read issued now
               k_in    = sum[RANK_W-1:0];
               rd_en   = 1'b1;
               rd_addr = binom_addr(n_ff - cand - 1'b1, q_rem);
            end else begin
               pend_elem_in = cand;
               pend_pos_in  = idx_ff;
               pend_last_in = 1'b0;
               pend_err_in  = 1'b0;
               if (out_free) begin
                  out_load = 1'b1;
                  idx_in   = idx_ff + 1'b1;
                  state_in = last_middle ? ST_FINAL : ST_ISSUE;
               end else begin
                  state_in = ST_PUT;
               end
            end
         end
         ST_FINAL: begin
            // last element follows from the remaining offset
            pend_elem_in = cur_ff + offset[ELEM_W-1:0];
            pend_pos_in  = idx_ff;
            pend_last_in = 1'b1;
            pend_err_in  = 1'b0;
            state_in     = ST_PUT;
         end
         ST_PUT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (pend_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = last_middle ? ST_FINAL : ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff      <= rank_in;
      k_ff         <= k_in;
      cur_ff       <= cur_in;
      idx_ff       <= idx_in;
      n_ff         <= n_in;
      p_ff         <= p_in;
      pend_elem_ff <= pend_elem_in;
      pend_pos_ff  <= pend_pos_in;
      pend_last_ff <= pend_last_in;
      pend_err_ff  <= pend_err_in;
   end

   // output register, loaded from the new or held pending result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_elem_ff <= pend_elem_in;
         rsp_pos_ff  <= pend_pos_in;
         rsp_last_ff <= pend_last_in;
         rsp_err_ff  <= pend_err_in;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.element_value = rsp_elem_ff;
   assign rsp_port.position      = rsp_pos_ff;
   assign rsp_port.last          = rsp_last_ff;
   assign rsp_port.rank_error    = rsp_err_ff;

   `CU_ASSERT_IMPLIES(a_accept_after_fill, clock, reset, req_accept, fill_done, "request taken before table build finished")
   `CU_ASSERT_IMPLIES(a_load_when_free, clock, reset, out_load, out_free, "output register overwritten while stalled")
   `CU_ASSERT_IMPLIES(a_cand_in_set, clock, reset, state_ff == ST_CHECK, cur_ff < n_ff, "candidate stepped past the set size")
   `CU_ASSERT_IMPLIES(a_error_shape, clock, reset, rsp_valid_ff && rsp_err_ff, (rsp_elem_ff == '0) && rsp_last_ff && (rsp_pos_ff == '0), "error response with nonzero fields")
endmodule

FILE: test/combination_unrank_tb.sv
// testbench for combination_unrank: ranks are unranked by a built-in predictor and every
// response transaction is checked field by field; depends on cu_pkg, cu_channels and
// the combination_unrank top level
module combination_unrank_tb;
   import cu_pkg::*;

   localparam int unsigned RANK_MAX    = (1 << RANK_W) - 1;
   localparam int          RANDOM_RANKS = 330;
   localparam int          SETTLE_CYCLES = 100;

   // one response transaction, field order as on the response channel
   typedef struct packed {
      logic [ELEM_W-1:0] element_value;
      logic [POS_W-1:0]  position;
      logic              last;
      logic              rank_error;
   } element_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   cu_req_if req_port();
   cu_rsp_if rsp_port();

   // ranks waiting to be sent, and elements the block still owes us
   logic [RANK_W-1:0] pending_ranks[$];
   element_type       expected_elements[$];

   // our copy of the two size registers
   logic [SET_W-1:0]  set_size_reg;
   logic [SUB_W-1:0]  subset_size_reg;

   // idle percentages of sender and receiver
   int req_gap_pct;
   int rsp_stall_pct;
   int error_count;

   combination_unrank u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_port),
      .rsp_port         (rsp_port),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // exact binomial coefficient, zero when b exceeds a
   function automatic longint unsigned binomial(input int unsigned a, input int unsigned b);
      longint unsigned acc = 1;
      int unsigned     k;
      if (b > a) return 0;
      k = (b > a - b) ? a - b : b;
      for (int unsigned i = 1; i <= k; i++)
         acc = acc * (a - k + i) / i;
      return acc;
   endfunction

   // unrank one rank under the current sizes and queue the elements it should give
   task automatic predict_subset(input logic [RANK_W-1:0] rank);
      int unsigned     n;
      int unsigned     p;
      int unsigned     cur;
      longint unsigned target;
      longint unsigned sum;
      longint unsigned term;
      n      = 32'(set_size_reg);
      p      = 32'(subset_size_reg);
      target = 64'(rank);
      sum    = 0;
      cur    = 0;
      term   = 0;
      // bad sizes or rank outside 1..C(n,p): one error transaction
      if (n == 0 || p == 0 || n > MAX_SET_SIZE || p > MAX_SUBSET_SIZE || p > n ||
          target == 0 || target > binomial(n, p)) begin
         expected_elements.push_back('{element_value: '0, position: '0,
                                       last: 1'b1, rank_error: 1'b1});
         return;
      end
      // every element but the last: step the candidate until the sum reaches the rank
      for (int unsigned i = 0; i + 1 < p; i++) begin
         do begin
            cur++;
            term = binomial(n - cur, p - (i + 1));
            sum += term;
         end while (sum < target && cur < n);
         sum -= term;
         expected_elements.push_back('{element_value: ELEM_W'(cur), position: POS_W'(i),
                                       last: 1'b0, rank_error: 1'b0});
      end
      // last element is the remaining offset; with one element this is the rank itself
      cur = cur + int'(target - sum);
      expected_elements.push_back('{element_value: ELEM_W'(cur), position: POS_W'(p - 1),
                                    last: 1'b1, rank_error: 1'b0});
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // sampled on the falling edge so that posedge updates have all settled
   task automatic wait_for_idle;
      do @(negedge clock);
      while (pending_ranks.size() != 0 || req_port.valid || expected_elements.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_SET_SIZE) set_size_reg = data[SET_W-1:0];
      else subset_size_reg = data[SUB_W-1:0];
   endtask

   // sizes change only once the block has gone quiet
   task automatic write_sizes(input int n, input int p);
      wait_for_idle();
      write_register(CSR_SET_SIZE, CSR_DATA_W'(n));
      // top data bit is beyond the subset register and must be dropped
      write_register(CSR_SUBSET_SIZE, {1'($urandom_range(0, 1)), SUB_W'(p)});
   endtask

   // request driver: holds a transaction until taken, then maybe inserts a gap
   always @(posedge clock) begin
      if (reset) begin
         req_port.valid <= 1'b0;
      end else begin
         if (req_port.valid && req_port.ready) predict_subset(req_port.rank);
         if (!req_port.valid || req_port.ready) begin
            if (pending_ranks.size() != 0 && $urandom_range(0, 99) >= req_gap_pct) begin
               req_port.valid <= 1'b1;
               req_port.rank  <= pending_ranks.pop_front();
            end else begin
               req_port.valid <= 1'b0;
            end
         end
      end
   end

   // response receiver: random back-pressure
   always @(posedge clock) begin
      rsp_port.ready <= !reset && ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // response monitor: each accepted transaction against the oldest expectation
   always @(posedge clock) begin : element_monitor
      element_type got;
      element_type want;
      if (!reset && rsp_port.valid && rsp_port.ready) begin
         got = {rsp_port.element_value, rsp_port.position, rsp_port.last, rsp_port.rank_error};
         if (expected_elements.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction value %0d pos %0d last %0b err %0b",
                                      got.element_value, got.position, got.last,
                                      got.rank_error));
         end else begin
            want = expected_elements.pop_front();
            if (got !== want)
               report_mismatch($sformatf(
                  "value %0d/%0d pos %0d/%0d last %0b/%0b err %0b/%0b (got/exp)",
                  got.element_value, want.element_value, got.position, want.position,
                  got.last, want.last, got.rank_error, want.rank_error));
         end
      end
   end

   // hard limit, far beyond the slowest passing run
   initial begin
      #8_000_000;
      $display("** combination_unrank: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int          n;
      int          p;
      int          count;
      int          sel;
      int          ranks_queued;
      int unsigned total;
      bit          sizes_ok;

      // known values everywhere before the first edge
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_SET_SIZE;
      csr_write_data   = '0;
      req_port.valid   = 1'b0;
      req_port.rank    = '0;
      rsp_port.ready   = 1'b0;
      set_size_reg     = SET_SIZE_RESET;
      subset_size_reg  = SUBSET_SIZE_RESET;
      req_gap_pct      = 7;
      rsp_stall_pct    = 67;
      error_count      = 0;
      ranks_queued     = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset sizes n=32 p=1, single element equals the rank
      pending_ranks.push_back(RANK_W'(1));
      pending_ranks.push_back(RANK_W'(32));
      pending_ranks.push_back(RANK_W'(33));
      pending_ranks.push_back(RANK_W'(0));
      // largest table corner, largest valid rank and just beyond
      write_sizes(MAX_SET_SIZE, MAX_SUBSET_SIZE);
      pending_ranks.push_back(RANK_W'(1));
      pending_ranks.push_back(RANK_W'(601080390));
      pending_ranks.push_back(RANK_W'(601080391));
      pending_ranks.push_back(RANK_W'(RANK_MAX));
      pending_ranks.push_back(RANK_W'(300000000));
      // smallest set
      write_sizes(1, 1);
      pending_ranks.push_back(RANK_W'(1));
      pending_ranks.push_back(RANK_W'(2));
      // whole set chosen, only one combination
      write_sizes(5, 5);
      pending_ranks.push_back(RANK_W'(1));
      pending_ranks.push_back(RANK_W'(2));
      // subset larger than set
      write_sizes(5, 6);
      pending_ranks.push_back(RANK_W'(1));
      // empty set
      write_sizes(0, 1);
      pending_ranks.push_back(RANK_W'(1));
      // set beyond the table, including the all-ones register value
      write_sizes(MAX_SET_SIZE + 1, 1);
      pending_ranks.push_back(RANK_W'(1));
      write_sizes(63, MAX_SUBSET_SIZE);
      pending_ranks.push_back(RANK_W'(5));
      // empty subset
      write_sizes(20, 0);
      pending_ranks.push_back(RANK_W'(1));
      // subset beyond the table
      write_sizes(MAX_SET_SIZE, MAX_SUBSET_SIZE + 1);
      pending_ranks.push_back(RANK_W'(1));
      write_sizes(MAX_SET_SIZE, 31);
      pending_ranks.push_back(RANK_W'(1));
      // mid-size, middle, last and one past the last rank
      write_sizes(6, 3);
      pending_ranks.push_back(RANK_W'(10));
      pending_ranks.push_back(RANK_W'(20));
      pending_ranks.push_back(RANK_W'(21));

      // random phases: new sizes, then a burst of ranks
      while (ranks_queued < RANDOM_RANKS) begin
         // sender mostly busy first, then receiver mostly busy, then no idling
         if (ranks_queued < RANDOM_RANKS / 3) begin
            req_gap_pct   = 7;
            rsp_stall_pct = 67;
         end else if (ranks_queued < 2 * RANDOM_RANKS / 3) begin
            req_gap_pct   = 67;
            rsp_stall_pct = 7;
         end else begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end

         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            // sizes the block must refuse
            case ($urandom_range(0, 4))
               0: begin n = 0; p = $urandom_range(0, MAX_SUBSET_SIZE); end
               1: begin n = $urandom_range(MAX_SET_SIZE + 1, 63); p = $urandom_range(1, 16); end
               2: begin n = $urandom_range(1, MAX_SET_SIZE); p = 0; end
               3: begin n = MAX_SET_SIZE; p = $urandom_range(MAX_SUBSET_SIZE + 1, 31); end
               default: begin n = $urandom_range(1, 15); p = $urandom_range(n + 1, 16); end
            endcase
         end else if (sel < 18) begin
            case ($urandom_range(0, 3))
               0: begin n = MAX_SET_SIZE; p = MAX_SUBSET_SIZE; end
               1: begin n = MAX_SET_SIZE; p = 1; end
               2: begin n = 1; p = 1; end
               default: begin n = MAX_SUBSET_SIZE; p = MAX_SUBSET_SIZE; end
            endcase
         end else begin
            n = $urandom_range(1, MAX_SET_SIZE);
            p = $urandom_range(1, (n < MAX_SUBSET_SIZE) ? n : MAX_SUBSET_SIZE);
         end
         write_sizes(n, p);

         sizes_ok = n >= 1 && n <= MAX_SET_SIZE && p >= 1 && p <= MAX_SUBSET_SIZE && p <= n;
         total    = sizes_ok ? int'(binomial(n, p)) : 0;
         count    = $urandom_range(6, 24);
         for (int k = 0; k < count; k++) begin
            // now and then hold the sender until every element has come back
            if (k == count / 2 && $urandom_range(0, 3) == 0) wait_for_idle();
            sel = $urandom_range(0, 99);
            if (!sizes_ok)
               pending_ranks.push_back(RANK_W'((sel < 50) ? $urandom_range(0, 3)
                                                          : $urandom_range(0, RANK_MAX)));
            else if (sel < 70)
               pending_ranks.push_back(RANK_W'($urandom_range(1, total)));
            else if (sel < 80)
               pending_ranks.push_back(RANK_W'($urandom_range(0, 1) ? 1 : total));
            else if (sel < 90)
               pending_ranks.push_back(RANK_W'($urandom_range(total + 1, RANK_MAX)));
            else if (sel < 95)
               pending_ranks.push_back(RANK_W'(0));
            else
               pending_ranks.push_back(RANK_W'($urandom()));
            ranks_queued++;
         end
      end

      // drain, then watch a while for stray transactions
      wait_for_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_elements.size() == 0)
         $display("** combination_unrank: PASSED **");
      else
         $display("** combination_unrank: FAILED **");
      $finish;
   end

endmodule
